FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// plain clocked assertion, disabled in reset
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: label");
// assertion that is also checked during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: label");
`endif

FILE: rtl/core/ibs_pkg.sv
// Types and constants of the bounding sphere block.
// No dependencies.
package ibs_pkg;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               start_new;
   } req_type;

   typedef struct packed {
      logic               was_inside;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic        [32:0] radius;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQRT,
      ST_CMP,
      ST_MUL,
      ST_DIV,
      ST_ADD,
      ST_OUT
   } state_type;

   // root width, square sum width, quotient width
   localparam int RootW = 34;
   localparam int SumW  = 68;
   localparam int ProdW = 66;

   // controls between the sequencer and the shared arithmetic unit
   typedef enum logic [1:0] {
      OP_NONE,
      OP_SQRT,
      OP_DIV
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        start;
   } alu_ctl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
   } alu_sts_type;

endpackage

FILE: rtl/core/ibs_iter_unit.sv
// Shared restoring iterative unit: square root or division, one bit a cycle.
// Depends on ibs_pkg.
module ibs_iter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  ibs_pkg::alu_ctl_type              ctl,
   input  logic [ibs_pkg::SumW-1:0]          opa,
   input  logic [ibs_pkg::RootW-1:0]         opb,
   output ibs_pkg::alu_sts_type              sts,
   output logic [ibs_pkg::ProdW-1:0]         result
);
   import ibs_pkg::*;

   localparam int CntW = 7;
   localparam int RemW = SumW + 2;

   op_type          op_ff, op_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [SumW-1:0] src_ff, src_in;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [ProdW-1:0] q_ff, q_in;
   logic [RootW-1:0] div_ff, div_in;

   logic [RemW-1:0] trial;
   logic [RemW-1:0] rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_NONE;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      src_ff <= src_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      rem_sh  = '0;
      trial   = '0;
      if (ctl.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         src_in  = opa;
         div_in  = opb;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = (ctl.op == OP_SQRT) ? CntW'(RootW) : CntW'(ProdW);
      end else if (busy_ff) begin
         case (op_ff)
            OP_SQRT: begin
               // two bits of radicand in, one root bit out
               rem_sh = {rem_ff[RemW-3:0], src_ff[SumW-1 -: 2]};
               trial  = {2'b00, q_ff, 2'b01};
               src_in = {src_ff[SumW-3:0], 2'b00};
               if (rem_sh >= trial) begin
                  rem_in = rem_sh - trial;
                  q_in   = {q_ff[ProdW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  q_in   = {q_ff[ProdW-2:0], 1'b0};
               end
            end
            OP_DIV: begin
               rem_sh = {rem_ff[RemW-2:0], src_ff[ProdW-1]};
               trial  = RemW'(div_ff);
               src_in = {src_ff[SumW-2:0], 1'b0};
               if (rem_sh >= trial) begin
                  rem_in = rem_sh - trial;
                  q_in   = {q_ff[ProdW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  q_in   = {q_ff[ProdW-2:0], 1'b0};
               end
            end
            default: begin
               rem_in = rem_ff;
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = q_ff;
endmodule

FILE: rtl/core/incremental_bounding_sphere.sv
// Incremental bounding sphere: 1 item in, 1 item out, Q16.16 coordinates.
// Restart or first item: taken as the new center with radius zero. Inside point: squares,
// then the root (34 root steps). Growing point: one shared root/divide unit runs the root
// and then three 66-step divides, one per axis. Not ready while busy.
// Reset (synchronous, active high) empties the sphere and clears the handshake.
module incremental_bounding_sphere (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ibs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ibs_pkg::rsp_type  rsp_data
);
   import ibs_pkg::*;

   state_type state_ff, state_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [32:0] rad_ff, rad_in;
   logic        def_ff, def_in;
   logic signed [32:0] dv_ff [3];
   logic signed [32:0] dv_in [3];
   logic [SumW-1:0] acc_ff, acc_in;
   logic [1:0]  ax_ff, ax_in;
   logic [RootW-1:0] d_ff, d_in, num_ff, num_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic        rv_ff, rv_in, ins_ff, ins_in;

   alu_ctl_type ctl;
   alu_sts_type sts;
   logic [ProdW-1:0] alu_res;
   logic [SumW-1:0]  alu_a;

   logic [32:0] mag_sel;
   logic [65:0] sq;
   logic [RootW-1:0] nr;
   logic signed [33:0] newc;

   ibs_iter_unit u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .opa    (alu_a),
      .opb    (d_ff),
      .sts    (sts),
      .result (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
         rad_ff <= '0;
         def_ff <= 1'b0;
         rv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
         rad_ff <= rad_in;
         def_ff <= def_in;
         rv_ff  <= rv_in;
      end
      for (int i = 0; i < 3; i++) dv_ff[i] <= dv_in[i];
      acc_ff  <= acc_in;
      ax_ff   <= ax_in;
      d_ff    <= d_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      ins_ff  <= ins_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = '{was_inside: ins_ff, center_x: cx_ff, center_y: cy_ff,
                        center_z: cz_ff, radius: rad_ff};

   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      rad_in = rad_ff; def_in = def_ff;
      for (int i = 0; i < 3; i++) dv_in[i] = dv_ff[i];
      acc_in = acc_ff; ax_in = ax_ff; d_in = d_ff; num_in = num_ff;
      prod_in = prod_ff; rv_in = rv_ff; ins_in = ins_ff;
      ctl.op = OP_NONE; ctl.start = 1'b0;
      alu_a = acc_ff;
      mag_sel = dv_ff[ax_ff][32] ? 33'(-dv_ff[ax_ff]) : 33'(dv_ff[ax_ff]);
      sq = 66'(mag_sel) * 66'(mag_sel);
      nr = RootW'((35'(rad_ff) + 35'(d_ff)) >> 1);
      newc = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.start_new || !def_ff) begin
                  cx_in = req_data.point_x; cy_in = req_data.point_y;
                  cz_in = req_data.point_z;
                  rad_in = '0; def_in = 1'b1; ins_in = 1'b0;
                  rv_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  dv_in[0] = 33'(req_data.point_x) - 33'(cx_ff);
                  dv_in[1] = 33'(req_data.point_y) - 33'(cy_ff);
                  dv_in[2] = 33'(req_data.point_z) - 33'(cz_ff);
                  acc_in = '0; ax_in = '0;
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            // one square per cycle into the running sum
            acc_in = acc_ff + SumW'(sq);
            if (ax_ff == 2'd2) state_in = ST_SQRT;
            else ax_in = ax_ff + 2'd1;
         end
         ST_SQRT: begin
            ctl.op = OP_SQRT; ctl.start = !sts.busy && !sts.done;
            if (sts.done) begin
               d_in = alu_res[RootW-1:0];
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (d_ff <= RootW'(rad_ff)) begin
               ins_in = 1'b1; rv_in = 1'b1; state_in = ST_OUT;
            end else begin
               ins_in = 1'b0;
               num_in = d_ff - nr;
               rad_in = nr[32:0];
               ax_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = ProdW'(mag_sel) * ProdW'(num_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            alu_a = SumW'(prod_ff);
            ctl.op = OP_DIV; ctl.start = !sts.busy && !sts.done;
            if (sts.done) begin
               prod_in = alu_res;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            case (ax_ff)
               2'd0: newc = 34'(cx_ff);
               2'd1: newc = 34'(cy_ff);
               default: newc = 34'(cz_ff);
            endcase
            if (dv_ff[ax_ff][32]) newc = newc - 34'(prod_ff);
            else                  newc = newc + 34'(prod_ff);
            case (ax_ff)
               2'd0: cx_in = newc[31:0];
               2'd1: cy_in = newc[31:0];
               default: cz_in = newc[31:0];
            endcase
            if (ax_ff == 2'd2) begin
               rv_in = 1'b1; state_in = ST_OUT;
            end else begin
               ax_in = ax_ff + 2'd1; state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rv_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: rtl/core/ibs_checker.sv
// Port-level checker for the bounding sphere block, with its bind.
// Depends on ibs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ibs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ibs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ibs_pkg::rsp_type rsp_data
);
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `CHK_ASSERT(a_no_overlap, clock, reset, rsp_valid |-> !req_ready)
   `CHK_ASSERT(a_restart_center, clock, reset, req_valid && req_ready && req_data.start_new |=> rsp_valid && rsp_data.radius == 33'd0 && !rsp_data.was_inside && rsp_data.center_x == $past(req_data.point_x))
   `CHK_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)
endmodule

bind incremental_bounding_sphere ibs_checker u_ibs_checker (.*);
